/* src/pidtc_pkg.sv */
// Shared types, register codes and reset values for the PID temperature controller.
`timescale 1ns / 1ps
`default_nettype none

package pidtc_pkg;

  // Field widths
  localparam int unsigned SampleW = 10;
  localparam int unsigned TempW   = 19;
  localparam int unsigned ErrW    = 21;  // internal error width
  localparam int unsigned ErrOutW = 20;  // error as reported
  localparam int unsigned GainW   = 16;
  localparam int unsigned DelayW  = 8;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned IntegW  = 32;
  localparam int unsigned CountW  = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 19;

  // Temperature per ADC step, 1/1024 degree units
  localparam int unsigned TempScale = 500;
  // Terms carry 18 fractional bits (Q8.8 gain times 1/1024 error)
  localparam int unsigned TermShift = 18;
  localparam int unsigned DutyMax   = 255;

  localparam logic [CountW-1:0] CountSat = '1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegTarget      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKp          = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKi          = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKd          = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIntegMargin = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIntegDelay  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDriveThr    = 3'd6;
  localparam logic [CfgIdxW-1:0] RegRelayThr    = 3'd7;

  // Reset values
  localparam logic [TempW-1:0]  TargetRst      = 19'd20480;
  localparam logic [GainW-1:0]  KpRst          = 16'd10240;
  localparam logic [GainW-1:0]  KiRst          = 16'd1280;
  localparam logic [GainW-1:0]  KdRst          = 16'd1280;
  localparam logic [GainW-1:0]  IntegMarginRst = 16'd922;
  localparam logic [DelayW-1:0] IntegDelayRst  = 8'd10;
  localparam logic [GainW-1:0]  DriveThrRst    = 16'd512;
  localparam logic [GainW-1:0]  RelayThrRst    = 16'd512;

  typedef struct packed {
    logic [TempW-1:0]  target_temp;
    logic [GainW-1:0]  kp_gain;
    logic [GainW-1:0]  ki_gain;
    logic [GainW-1:0]  kd_gain;
    logic [GainW-1:0]  integral_margin;
    logic [DelayW-1:0] integral_delay;
    logic [GainW-1:0]  drive_threshold;
    logic [GainW-1:0]  relay_threshold;
  } pidtc_cfg_t;

  typedef struct packed {
    logic [DutyW-1:0]          fan_duty;
    logic                      heater_relay;
    logic [TempW-1:0]          temperature;
    logic signed [ErrOutW-1:0] temp_error;
  } pidtc_res_t;

  // Divide a term by 2^18, rounding toward zero
  function automatic logic signed [21:0] trunc_term(input logic signed [39:0] x);
    logic signed [39:0] adj;
    adj = x + (x[39] ? 40'sd262143 : 40'sd0);
    return adj[39:TermShift];
  endfunction

endpackage

`default_nettype wire

/* src/pidtc_datapath.sv */
// Control law for one sample: error, P/I/D terms, integration gate, fan and relay.
`timescale 1ns / 1ps
`default_nettype none

module pidtc_datapath
  import pidtc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pidtc_cfg_t         cfg_i,
  input  wire logic [SampleW-1:0] sample_i,
  input  wire logic               step_i,
  output pidtc_res_t              res_o
);

  logic signed [ErrW-1:0]   last_err_q, last_err_d;
  logic signed [IntegW-1:0] integ_q, integ_d;
  logic [CountW-1:0]        count_q, count_d;

  logic [TempW-1:0]         temp;
  logic signed [ErrW-1:0]   err;
  logic [ErrW-1:0]          abs_err;
  logic signed [ErrW:0]     err_diff;
  logic signed [37:0]       p_full;
  logic signed [37:0]       i_full;
  logic signed [38:0]       d_full;
  logic signed [38:0]       acc;
  logic signed [IntegW-1:0] acc_sat;
  logic                     in_margin;
  logic                     integ_on;
  logic signed [23:0]       term_sum;
  logic [DutyW-1:0]         duty;

  // Temperature and error
  assign temp     = TempW'(sample_i) * TempW'(TempScale);
  assign err      = $signed({2'b00, temp}) - $signed({2'b00, cfg_i.target_temp});
  assign abs_err  = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);
  assign err_diff = (ErrW+1)'(err) - (ErrW+1)'(last_err_q);

  // Gain products
  assign p_full = 38'($signed({1'b0, cfg_i.kp_gain})) * 38'(err);
  assign i_full = 38'($signed({1'b0, cfg_i.ki_gain})) * 38'(err);
  assign d_full = 39'($signed({1'b0, cfg_i.kd_gain})) * 39'(err_diff);

  // Integral accumulate with 32-bit saturation
  assign acc = 39'(integ_q) + 39'(i_full);
  always_comb begin
    if (acc > 39'sd2147483647) begin
      acc_sat = 32'sh7FFF_FFFF;
    end else if (acc < -39'sd2147483648) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = acc[IntegW-1:0];
    end
  end

  // Integration gate: count in-margin samples, clear on leaving the margin
  assign in_margin = abs_err <= ErrW'(cfg_i.integral_margin);
  assign integ_on  = count_q > CountW'(cfg_i.integral_delay);

  always_comb begin
    if (!in_margin) begin
      integ_d = '0;
      count_d = '0;
    end else if (integ_on) begin
      integ_d = acc_sat;
      count_d = CountSat;
    end else begin
      integ_d = integ_q;
      count_d = count_q + CountW'(1);
    end
  end

  assign last_err_d = err;

  // Sum of terms truncated to whole duty units
  assign term_sum = 24'(trunc_term(40'(p_full))) + 24'(trunc_term(40'(integ_d)))
                  + 24'(trunc_term(40'(d_full)));

  // Clamp the duty; drive only above the threshold
  always_comb begin
    if (err <= $signed({5'b00000, cfg_i.drive_threshold})) begin
      duty = '0;
    end else if (term_sum < 24'sd0) begin
      duty = '0;
    end else if (term_sum > 24'(DutyMax)) begin
      duty = DutyW'(DutyMax);
    end else begin
      duty = term_sum[DutyW-1:0];
    end
  end

  assign res_o.fan_duty     = duty;
  assign res_o.heater_relay = err <= -$signed({5'b00000, cfg_i.relay_threshold});
  assign res_o.temperature  = temp;
  assign res_o.temp_error   = err[ErrOutW-1:0];

  // Advance controller state once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      integ_q    <= '0;
      count_q    <= '0;
    end else if (step_i) begin
      last_err_q <= last_err_d;
      integ_q    <= integ_d;
      count_q    <= count_d;
    end
  end

  // Counter either saturated or still counting toward the delay
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CountSat) || (count_q <= CountW'(256)))
    else $error("margin counter out of range");

  // A nonzero integral only exists once integration has started
  a_integ_gated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q != '0) |-> (count_q == CountSat))
    else $error("integral nonzero while integration is off");

endmodule

`default_nettype wire

/* src/pid_temperature_controller.sv */
// Top level of the PID temperature controller: config registers, pipeline and handshakes.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   adc_sample_i
//   out      output     out_valid_o / out_stall_i fan_duty_o, heater_relay_o,
//                                                 temperature_o, temp_error_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One word per cycle sustained while out_stall_i is low; a result is offered from the result
// register once its sample has passed the sample register. The sample register feeds a single
// combinational pass (two 16x21 and one 16x22 multiply, integral add and clamp) into the result
// register; controller state updates as the result loads. Reset clears controller state and loads default gains.
// A stalled result holds; the sample register keeps taking words while it is empty
// or the result register is free or draining. Config writes are always ready.
`timescale 1ns / 1ps
`default_nettype none

module pid_temperature_controller
  import pidtc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Sample channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [SampleW-1:0] adc_sample_i,
  // Result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [DutyW-1:0]        fan_duty_o,
  output logic                    heater_relay_o,
  output logic [TempW-1:0]        temperature_o,
  output logic [ErrOutW-1:0]      temp_error_o,
  // Config write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgDatW-1:0] cfg_data_i
);

  pidtc_cfg_t         cfg_q;
  logic               s1_valid_q;
  logic [SampleW-1:0] s1_sample_q;
  logic               out_valid_q;
  pidtc_res_t         res_q;
  pidtc_res_t         res;
  logic               advance;
  logic               in_take;

  // Config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp     <= TargetRst;
      cfg_q.kp_gain         <= KpRst;
      cfg_q.ki_gain         <= KiRst;
      cfg_q.kd_gain         <= KdRst;
      cfg_q.integral_margin <= IntegMarginRst;
      cfg_q.integral_delay  <= IntegDelayRst;
      cfg_q.drive_threshold <= DriveThrRst;
      cfg_q.relay_threshold <= RelayThrRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegTarget:      cfg_q.target_temp     <= cfg_data_i;
        RegKp:          cfg_q.kp_gain         <= cfg_data_i[GainW-1:0];
        RegKi:          cfg_q.ki_gain         <= cfg_data_i[GainW-1:0];
        RegKd:          cfg_q.kd_gain         <= cfg_data_i[GainW-1:0];
        RegIntegMargin: cfg_q.integral_margin <= cfg_data_i[GainW-1:0];
        RegIntegDelay:  cfg_q.integral_delay  <= cfg_data_i[DelayW-1:0];
        RegDriveThr:    cfg_q.drive_threshold <= cfg_data_i[GainW-1:0];
        RegRelayThr:    cfg_q.relay_threshold <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: result register loads when empty or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take || advance) begin
      s1_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_sample_q <= adc_sample_i;
    end
  end

  pidtc_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .sample_i (s1_sample_q),
    .step_i   (s1_valid_q && advance),
    .res_o    (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fan_duty_o     = res_q.fan_duty;
  assign heater_relay_o = res_q.heater_relay;
  assign temperature_o  = res_q.temperature;
  assign temp_error_o   = res_q.temp_error;

  // A word taken while the sample register is full needs the held word to move on in the same cycle
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && s1_valid_q) |-> advance)
    else $error("sample register overwritten");

  // A word leaving the sample register shows up as a result next cycle
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && advance) |=> out_valid_o)
    else $error("result lost");

  // Fan drive and heater relay are never on together
  a_fan_relay_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !((fan_duty_o != '0) && heater_relay_o))
    else $error("fan and heater both on");

endmodule

`default_nettype wire
